>>> src/tcmdw_pkg.sv
package tcmdw_pkg;

  typedef enum logic [1:0] {
    OP_BYTE       = 2'd0,
    OP_TICK       = 2'd1,
    OP_DISCONNECT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2
  } frame_status_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_WS1   = 3'd1,
    PH_NUM1  = 3'd2,
    PH_SEC   = 3'd3,
    PH_SIGN2 = 3'd4,
    PH_DIG2  = 3'd5,
    PH_DONE  = 3'd6,
    PH_BAD   = 3'd7
  } phase_t;

  localparam logic [15:0] WATCHDOG_RESET = 16'd500;
  localparam logic [8:0]  MAG_SAT        = 9'd511;
  localparam logic [8:0]  SPEED_MAX      = 9'd255;

  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_NUL   = 8'd0;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // m*10 + digit, saturating at MAG_SAT
  function automatic logic [8:0] accumulate(input logic [8:0] m, input logic [7:0] c);
    logic [13:0] v;
    v = {2'b00, m, 3'b000} + {4'b0000, m, 1'b0} + {10'd0, c[3:0]};
    return (v > {5'd0, MAG_SAT}) ? MAG_SAT : v[8:0];
  endfunction

  function automatic logic [7:0] cap_speed(input logic [8:0] m);
    return (m > SPEED_MAX) ? SPEED_MAX[7:0] : m[7:0];
  endfunction

endpackage

>>> src/text_command_motor_drive_watchdog_unit.sv
// Two-motor drive from text frames "<left>,<right>", one byte per item, plus
// millisecond ticks and link disconnect items. Every accepted item produces one
// result item carrying both H-bridge direction bits, both PWM duties, the stale
// flag and the frame status. The parser, the x10 accumulate and the watchdog
// compare sit between the input handshake and the result register, so one item
// is taken per clock while no waiting result is stalled, and a new item is
// accepted while the previous result waits as long as that result is being
// taken in the same cycle. The result is valid in the cycle after acceptance.
// wr_en loads watchdog_ticks (motors off once more ticks than this have passed
// since the last good frame); write it only while the block is idle.
module text_command_motor_drive_watchdog_unit #(
  parameter int DUTY_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  byte_value,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        right_forward,
  output logic        right_reverse,
  output logic [7:0]  right_duty,
  output logic        left_forward,
  output logic        left_reverse,
  output logic [7:0]  left_duty,
  output logic        stale,
  output logic [1:0]  frame_status
);
  import tcmdw_pkg::*;

  localparam logic [16:0] DUTY_MAX = (17'd1 << DUTY_BITS) - 17'd1;

  logic [15:0] watchdog_ticks;
  phase_t      phase, phase_next;
  logic        first_neg, first_neg_next;
  logic [8:0]  first_mag, first_mag_next;
  logic        first_seen, first_seen_next;
  logic        second_neg, second_neg_next;
  logic [8:0]  second_mag, second_mag_next;
  logic        left_neg, left_neg_next;
  logic [7:0]  left_mag, left_mag_next;
  logic        right_neg, right_neg_next;
  logic [7:0]  right_mag, right_mag_next;
  logic        command_valid, command_valid_next;
  logic [15:0] ticks, ticks_next;
  frame_status_t status_next;
  logic        stale_next;
  logic        accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  function automatic logic [7:0] duty_of(input logic [7:0] m);
    return ({9'd0, m} > DUTY_MAX) ? DUTY_MAX[7:0] : m;
  endfunction

  always_comb begin
    phase_next         = phase;
    first_neg_next     = first_neg;
    first_mag_next     = first_mag;
    first_seen_next    = first_seen;
    second_neg_next    = second_neg;
    second_mag_next    = second_mag;
    left_neg_next      = left_neg;
    left_mag_next      = left_mag;
    right_neg_next     = right_neg;
    right_mag_next     = right_mag;
    command_valid_next = command_valid;
    ticks_next         = ticks;
    status_next        = ST_PENDING;

    case (operation)
      OP_BYTE: begin
        if (byte_value == CH_NUL) begin
          // NUL ends parsing: fatal before or inside the first number
          if (phase == PH_START || phase == PH_WS1 || phase == PH_NUM1) begin
            phase_next = PH_BAD;
          end else if (phase != PH_BAD) begin
            phase_next = PH_DONE;
          end
        end else begin
          case (phase)
            PH_START, PH_WS1: begin
              if (is_ws(byte_value)) begin
                phase_next = PH_WS1;
              end else if (byte_value == CH_PLUS || byte_value == CH_MINUS) begin
                first_neg_next = (byte_value == CH_MINUS);
                phase_next     = PH_NUM1;
              end else if (is_digit(byte_value)) begin
                first_mag_next  = accumulate(first_mag, byte_value);
                first_seen_next = 1'b1;
                phase_next      = PH_NUM1;
              end else if (byte_value == CH_COMMA && phase == PH_START) begin
                phase_next = PH_SEC;
              end else begin
                phase_next = PH_BAD;
              end
            end
            PH_NUM1: begin
              if (is_digit(byte_value)) begin
                first_mag_next  = accumulate(first_mag, byte_value);
                first_seen_next = 1'b1;
              end else if (byte_value == CH_COMMA && first_seen) begin
                phase_next = PH_SEC;
              end else begin
                phase_next = PH_BAD;
              end
            end
            PH_SEC: begin
              if (is_ws(byte_value)) begin
                phase_next = PH_SEC;
              end else if (byte_value == CH_PLUS || byte_value == CH_MINUS) begin
                second_neg_next = (byte_value == CH_MINUS);
                phase_next      = PH_SIGN2;
              end else if (is_digit(byte_value)) begin
                second_mag_next = accumulate(second_mag, byte_value);
                phase_next      = PH_DIG2;
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_SIGN2, PH_DIG2: begin
              if (is_digit(byte_value)) begin
                second_mag_next = accumulate(second_mag, byte_value);
                phase_next      = PH_DIG2;
              end else begin
                phase_next = PH_DONE;
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end

        if (frame_last) begin
          if (phase_next == PH_SEC || phase_next == PH_SIGN2 ||
              phase_next == PH_DIG2 || phase_next == PH_DONE) begin
            left_neg_next      = first_neg_next;
            left_mag_next      = cap_speed(first_mag_next);
            right_neg_next     = second_neg_next;
            right_mag_next     = cap_speed(second_mag_next);
            command_valid_next = 1'b1;
            ticks_next         = '0;
            status_next        = ST_ACCEPTED;
          end else begin
            status_next = ST_REJECTED;
          end
          phase_next      = PH_START;
          first_neg_next  = 1'b0;
          first_mag_next  = '0;
          first_seen_next = 1'b0;
          second_neg_next = 1'b0;
          second_mag_next = '0;
        end
      end
      OP_TICK: begin
        if (ticks != 16'hFFFF) begin
          ticks_next = ticks + 16'd1;
        end
      end
      OP_DISCONNECT: begin
        left_neg_next      = 1'b0;
        left_mag_next      = '0;
        right_neg_next     = 1'b0;
        right_mag_next     = '0;
        command_valid_next = 1'b0;
        phase_next         = PH_START;
        first_neg_next     = 1'b0;
        first_mag_next     = '0;
        first_seen_next    = 1'b0;
        second_neg_next    = 1'b0;
        second_mag_next    = '0;
      end
      default: begin
        status_next = ST_PENDING;
      end
    endcase

    stale_next = !command_valid_next || (ticks_next > watchdog_ticks);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      watchdog_ticks <= WATCHDOG_RESET;
    end else if (wr_en) begin
      watchdog_ticks <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      first_neg     <= 1'b0;
      first_mag     <= '0;
      first_seen    <= 1'b0;
      second_neg    <= 1'b0;
      second_mag    <= '0;
      left_neg      <= 1'b0;
      left_mag      <= '0;
      right_neg     <= 1'b0;
      right_mag     <= '0;
      command_valid <= 1'b0;
      ticks         <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      first_neg     <= first_neg_next;
      first_mag     <= first_mag_next;
      first_seen    <= first_seen_next;
      second_neg    <= second_neg_next;
      second_mag    <= second_mag_next;
      left_neg      <= left_neg_next;
      left_mag      <= left_mag_next;
      right_neg     <= right_neg_next;
      right_mag     <= right_mag_next;
      command_valid <= command_valid_next;
      ticks         <= ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload; a stale command drives both bridges off
  always_ff @(posedge clk) begin
    if (accept) begin
      right_forward <= !stale_next && !right_neg_next && (right_mag_next != 8'd0);
      right_reverse <= !stale_next && right_neg_next && (right_mag_next != 8'd0);
      right_duty    <= stale_next ? 8'd0 : duty_of(right_mag_next);
      left_forward  <= !stale_next && !left_neg_next && (left_mag_next != 8'd0);
      left_reverse  <= !stale_next && left_neg_next && (left_mag_next != 8'd0);
      left_duty     <= stale_next ? 8'd0 : duty_of(left_mag_next);
      stale         <= stale_next;
      frame_status  <= status_next;
    end
  end

  a_stale_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && stale |-> right_duty == 8'd0 && left_duty == 8'd0 &&
      !right_forward && !right_reverse && !left_forward && !left_reverse)
    else $error("stale result drives a motor");

  a_accept_fresh: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == ST_ACCEPTED |-> !stale)
    else $error("accepted frame reported stale");

  a_frame_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_BYTE && frame_last |=> phase == PH_START && !first_seen)
    else $error("parser not cleared at frame end");

  a_disconnect: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_DISCONNECT |=> !command_valid && stale)
    else $error("disconnect left a command active");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_status) && $stable(stale))
    else $error("result lost while stalled");

endmodule
